// File: hw/rtl/tslpe_pkg.sv
// ----------------------------------------------------------------------------
// tslpe_pkg
// shared types and constants of the transport stream lpcm payload extractor
// ----------------------------------------------------------------------------
package tslpe_pkg;

   // bytes in one transport packet
   localparam int unsigned TS_PACKET_BYTES = 188;
   // bytes in the transport packet header
   localparam int unsigned TS_HEADER_BYTES = 4;

   localparam int unsigned POS_WIDTH  = $clog2(TS_PACKET_BYTES);
   localparam int unsigned CSR_DATA_W = 13;

   // register reset values
   localparam logic [12:0] TARGET_PID_RESET       = 13'h1100;
   localparam logic [6:0]  RTP_HEADER_BYTES_RESET = 7'd12;
   localparam logic [7:0]  PES_HEADER_SKIP_RESET  = 8'd20;
   localparam logic        SWAP_ENABLE_RESET      = 1'b1;

   typedef enum logic [1:0] {
      CSR_TARGET_PID       = 2'd0,
      CSR_RTP_HEADER_BYTES = 2'd1,
      CSR_PES_HEADER_SKIP  = 2'd2,
      CSR_SWAP_ENABLE      = 2'd3
   } tslpe_csr_index_type;

   typedef struct packed {
      logic [12:0] target_pid;
      logic [6:0]  rtp_header_bytes;
      logic [7:0]  pes_header_skip;
      logic        swap_enable;
   } tslpe_cfg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       datagram_start;
      logic       slice_start;
   } tslpe_req_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        first_of_slice;
   } tslpe_rsp_type;

endpackage

// File: hw/rtl/ts_lpcm_payload_extractor_top.sv
// ----------------------------------------------------------------------------
// ts_lpcm_payload_extractor_top
// rtp / mpeg-2 transport stream depacketizer giving 16-bit lpcm samples
// ----------------------------------------------------------------------------
// path: the byte completing a sample passes the input register, then the result
//    register, before the sample is valid on rsp
// throughput: one byte per cycle, set by the single parse step between the
//    input register and the result register; a sample held on rsp while
//    rsp_ready is low stalls the input once the input register is full
// reset: synchronous, clears parse state, pairing and the valid flags of both
//    pipeline registers and loads the configuration registers with defaults
// ----------------------------------------------------------------------------
module ts_lpcm_payload_extractor_top
   import tslpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte stream
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tslpe_req_type         req_payload,
   // samples
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tslpe_rsp_type         rsp_payload,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tslpe_cfg_type cfg;

   // input register stage
   logic          s1_valid_ff, s1_valid_in;
   tslpe_req_type s1_item_ff;
   logic          s1_advance;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   tslpe_rsp_type rsp_item_ff;

   logic          emit;
   tslpe_rsp_type result;

   // configuration is always writable; the user must write it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   tslpe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid & csr_ready),
      .write_index (tslpe_csr_index_type'(csr_index)),
      .write_data  (csr_wdata),
      .cfg         (cfg)
   );

   // the held byte moves on once the result register is free or draining
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   // a new transaction enters whenever the input register is empty or empties this cycle
   assign req_ready  = ~s1_valid_ff | s1_advance;

   tslpe_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (s1_advance),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      s1_valid_in = (req_valid & req_ready) | (s1_valid_ff & ~s1_advance);
      // a pending result is never overwritten: s1_advance implies it drains
      if (s1_advance) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         s1_item_ff <= req_payload;
      end
      if (s1_advance & emit) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

// File: hw/rtl/tslpe_csr.sv
// ----------------------------------------------------------------------------
// tslpe_csr
// configuration registers written over the csr channel
// ----------------------------------------------------------------------------
module tslpe_csr
   import tslpe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write_en,
   input  tslpe_csr_index_type       write_index,
   input  logic [CSR_DATA_W-1:0]     write_data,
   output tslpe_cfg_type             cfg
);

   tslpe_cfg_type cfg_ff;
   tslpe_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (write_index)
            CSR_TARGET_PID:       cfg_in.target_pid       = write_data[12:0];
            CSR_RTP_HEADER_BYTES: cfg_in.rtp_header_bytes = write_data[6:0];
            CSR_PES_HEADER_SKIP:  cfg_in.pes_header_skip  = write_data[7:0];
            CSR_SWAP_ENABLE:      cfg_in.swap_enable      = write_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_pid       <= TARGET_PID_RESET;
         cfg_ff.rtp_header_bytes <= RTP_HEADER_BYTES_RESET;
         cfg_ff.pes_header_skip  <= PES_HEADER_SKIP_RESET;
         cfg_ff.swap_enable      <= SWAP_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/tslpe_parser.sv
// ----------------------------------------------------------------------------
// tslpe_parser
// datagram and packet header tracking, payload selection and byte pairing
// ----------------------------------------------------------------------------
module tslpe_parser
   import tslpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  tslpe_req_type   item,
   input  tslpe_cfg_type   cfg,
   output logic            emit,
   output tslpe_rsp_type   result
);

   logic [6:0]           skip_cnt_ff,  skip_cnt_in;
   logic [POS_WIDTH-1:0] pos_ff,       pos_in;
   logic [7:0]           hdr_byte1_ff, hdr_byte1_in;
   logic                 afc_ff,       afc_in;
   logic                 pid_match_ff, pid_match_in;
   logic [7:0]           limit_ff,     limit_in;
   logic [7:0]           held_ff,      held_in;
   logic                 parity_ff,    parity_in;
   logic                 first_ff,     first_in;

   logic                 dgram;
   logic [6:0]           skip_now;
   logic [POS_WIDTH-1:0] pos_cur;
   logic [POS_WIDTH:0]   pos_inc;
   logic [8:0]           limit_sum;
   logic                 payload_hit;
   logic                 parity_cur;
   logic                 first_cur;
   logic [7:0]           b;

   always_comb begin
      b            = item.in_byte;
      dgram        = item.datagram_start | item.slice_start;
      skip_now     = dgram ? cfg.rtp_header_bytes : skip_cnt_ff;
      pos_cur      = dgram ? '0 : pos_ff;
      pos_inc      = {1'b0, pos_cur} + 1'b1;
      parity_cur   = item.slice_start ? 1'b0 : parity_ff;
      first_cur    = item.slice_start ? 1'b1 : first_ff;
      limit_sum    = {1'b0, limit_ff} + 9'd1 + {1'b0, b};

      skip_cnt_in  = skip_cnt_ff;
      pos_in       = pos_cur;
      hdr_byte1_in = hdr_byte1_ff;
      afc_in       = afc_ff;
      pid_match_in = pid_match_ff;
      limit_in     = limit_ff;
      held_in      = held_ff;
      parity_in    = parity_cur;
      first_in     = first_cur;
      payload_hit  = 1'b0;
      emit         = 1'b0;

      if (skip_now != 7'd0) begin
         skip_cnt_in = skip_now - 7'd1;
      end else begin
         skip_cnt_in = 7'd0;
         case (pos_cur)
            POS_WIDTH'(0): begin
               hdr_byte1_in = 8'd0;
               afc_in       = 1'b0;
            end
            POS_WIDTH'(1): begin
               hdr_byte1_in = b;
            end
            POS_WIDTH'(2): begin
               pid_match_in = ({hdr_byte1_ff[4:0], b} == cfg.target_pid);
            end
            POS_WIDTH'(3): begin
               afc_in   = b[5];
               // pusi selects the fixed pes header skip
               limit_in = hdr_byte1_ff[6] ? cfg.pes_header_skip : 8'd0;
            end
            default: begin
               // adaptation field length byte extends the skip, saturating
               if (pos_cur == POS_WIDTH'(TS_HEADER_BYTES) && afc_ff) begin
                  limit_in = limit_sum[8] ? 8'hFF : limit_sum[7:0];
               end
               payload_hit = pid_match_ff &&
                  (8'(pos_cur - POS_WIDTH'(TS_HEADER_BYTES)) >= limit_in);
            end
         endcase
         pos_in = (pos_inc >= (POS_WIDTH+1)'(TS_PACKET_BYTES)) ? '0 : pos_inc[POS_WIDTH-1:0];

         if (payload_hit) begin
            if (!parity_cur) begin
               held_in   = b;
               parity_in = 1'b1;
            end else begin
               parity_in = 1'b0;
               first_in  = 1'b0;
               emit      = 1'b1;
            end
         end
      end

      result.sample         = cfg.swap_enable ? {b, held_ff} : {held_ff, b};
      result.first_of_slice = first_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_cnt_ff  <= '0;
         pos_ff       <= '0;
         hdr_byte1_ff <= '0;
         afc_ff       <= 1'b0;
         pid_match_ff <= 1'b0;
         limit_ff     <= '0;
         held_ff      <= '0;
         parity_ff    <= 1'b0;
         first_ff     <= 1'b1;
      end else if (step) begin
         skip_cnt_ff  <= skip_cnt_in;
         pos_ff       <= pos_in;
         hdr_byte1_ff <= hdr_byte1_in;
         afc_ff       <= afc_in;
         pid_match_ff <= pid_match_in;
         limit_ff     <= limit_in;
         held_ff      <= held_in;
         parity_ff    <= parity_in;
         first_ff     <= first_in;
      end
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rtp / transport stream lpcm payload extractor:
// random datagram slices are played into the byte port under bursty flow
// control, a built-in model predicts every lpcm sample, and each sample taken
// from the result port is compared field by field
// ----------------------------------------------------------------------------
module tb
   import tslpe_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int          HOLD_OFF_CYCLES = 250;
   localparam int          PHASE_BYTES     = 280;
   localparam int          PHASE_COUNT     = 7;

   // -------------------------------------------------------------------------
   // sample predictor and store of samples still due from the block
   // -------------------------------------------------------------------------
   class lpcm_sample_board;
      // register copies
      logic [12:0]   target_pid;
      logic [6:0]    rtp_bytes;
      logic [7:0]    pes_skip;
      logic          swap_en;
      // parse and pairing state
      logic [6:0]    hdr_left;
      logic [7:0]    pkt_pos;
      logic [23:0]   pkt_hdr;
      logic          pid_hit;
      logic [7:0]    skip_lim;
      logic [7:0]    held;
      logic          odd;
      logic          first_due;
      tslpe_rsp_type samples_due[$];
      int            mismatches;

      function new();
         target_pid = TARGET_PID_RESET;
         rtp_bytes  = RTP_HEADER_BYTES_RESET;
         pes_skip   = PES_HEADER_SKIP_RESET;
         swap_en    = SWAP_ENABLE_RESET;
         hdr_left   = '0;
         pkt_pos    = '0;
         pkt_hdr    = '0;
         pid_hit    = 1'b0;
         skip_lim   = '0;
         held       = '0;
         odd        = 1'b0;
         first_due  = 1'b1;
         mismatches = 0;
      endfunction

      function void write_reg(tslpe_csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TARGET_PID:       target_pid = data[12:0];
            CSR_RTP_HEADER_BYTES: rtp_bytes  = data[6:0];
            CSR_PES_HEADER_SKIP:  pes_skip   = data[7:0];
            CSR_SWAP_ENABLE:      swap_en    = data[0];
            default: ;
         endcase
      endfunction

      // one accepted byte transaction
      function void note_byte(tslpe_req_type r);
         logic          dg;
         logic          hit;
         int            lim;
         tslpe_rsp_type s;
         dg  = r.datagram_start;
         hit = 1'b0;
         if (r.slice_start) begin
            odd       = 1'b0;
            first_due = 1'b1;
            dg        = 1'b1;
         end
         if (dg) begin
            hdr_left = rtp_bytes;
            pkt_pos  = '0;
         end
         if (hdr_left != 0) begin
            hdr_left = hdr_left - 7'd1;
            return;
         end
         case (pkt_pos)
            8'd0: pkt_hdr = '0;
            8'd1: pkt_hdr = {r.in_byte, 16'h0000};
            8'd2: begin
               pkt_hdr[15:8] = r.in_byte;
               pid_hit = (pkt_hdr[20:8] == target_pid);
            end
            8'd3: begin
               pkt_hdr[7:0] = r.in_byte;
               skip_lim = pkt_hdr[22] ? pes_skip : 8'd0;
            end
            default: begin
               if (pkt_pos == 8'd4 && pkt_hdr[5]) begin
                  lim = int'(skip_lim) + 1 + int'(r.in_byte);
                  skip_lim = (lim > 255) ? 8'hFF : 8'(lim);
               end
               hit = pid_hit && ((pkt_pos - 8'd4) >= skip_lim);
            end
         endcase
         pkt_pos = (int'(pkt_pos) + 1 >= TS_PACKET_BYTES) ? 8'd0 : pkt_pos + 8'd1;
         if (!hit) return;
         if (!odd) begin
            held = r.in_byte;
            odd  = 1'b1;
            return;
         end
         odd = 1'b0;
         s.sample         = swap_en ? {r.in_byte, held} : {held, r.in_byte};
         s.first_of_slice = first_due;
         first_due = 1'b0;
         samples_due.push_back(s);
      endfunction

      // one accepted sample transaction
      function void check_sample(tslpe_rsp_type got);
         tslpe_rsp_type want;
         if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample %h first %b", got.sample, got.first_of_slice);
            return;
         end
         want = samples_due.pop_front();
         if (got.sample !== want.sample || got.first_of_slice !== want.first_of_slice) begin
            mismatches++;
            if (mismatches <= 10)
               $display("sample exp %h first %b, got %h first %b",
                        want.sample, want.first_of_slice, got.sample, got.first_of_slice);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   tslpe_req_type         req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   tslpe_rsp_type         rsp_payload;
   logic                  csr_valid   = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index   = CSR_TARGET_PID;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   lpcm_sample_board sb;
   tslpe_req_type    byte_q[$];      // bytes of the phase being played
   logic             hold_off_pending = 1'b0;
   int unsigned      cycle_count      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ts_lpcm_payload_extractor_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // watchdog: a hung handshake or a lost sample ends the run here
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ts_lpcm_payload_extractor_top: mismatch");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // result monitor, values read right after the edge are the pre-edge ones
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_sample(rsp_payload);
   end

   // -------------------------------------------------------------------------
   // receiver: ready runs of random length broken by short stalls, now and
   // then a long open stretch, and a long hold-off when the stimulus asks
   // -------------------------------------------------------------------------
   initial begin : rsp_stall_pattern
      int run;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            // long hold-off so the pipeline fills and req_ready drops
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
         repeat (run) @(posedge clock);
         if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // stream building
   // -------------------------------------------------------------------------
   function automatic void push_byte(logic [7:0] b, logic dg, logic sl);
      tslpe_req_type r;
      r.in_byte        = b;
      r.datagram_start = dg;
      r.slice_start    = sl;
      byte_q.push_back(r);
   endfunction

   // one transport packet, cut short after keep bytes
   function automatic void gen_packet(int keep);
      logic [12:0] pid;
      logic        pusi;
      logic [1:0]  afc;
      logic [7:0]  adapt;
      logic [7:0]  b;
      pid  = ($urandom_range(0, 3) != 0) ? sb.target_pid : 13'($urandom);
      pusi = 1'($urandom);
      afc  = 2'($urandom);
      // adaptation length: mostly short, sometimes to or past the packet end
      case ($urandom_range(0, 5))
         0:       adapt = 8'd183;
         1:       adapt = 8'($urandom);
         default: adapt = 8'($urandom_range(0, 30));
      endcase
      for (int i = 0; i < keep; i++) begin
         case (i)
            0:       b = ($urandom_range(0, 9) != 0) ? 8'h47 : 8'($urandom);
            1:       b = {1'($urandom), pusi, 1'($urandom), pid[12:8]};
            2:       b = pid[7:0];
            3:       b = {2'($urandom), afc, 4'($urandom)};
            4:       b = afc[1] ? adapt : 8'($urandom);
            default: b = 8'($urandom);
         endcase
         push_byte(b, 1'b0, 1'b0);
      end
   endfunction

   // rtp header then one or two packets, the last sometimes truncated
   function automatic void gen_datagram(logic new_slice);
      int start;
      int n_pkt;
      start = byte_q.size();
      for (int i = 0; i < int'(sb.rtp_bytes); i++)
         push_byte(8'($urandom), 1'b0, 1'b0);
      n_pkt = $urandom_range(1, 2);
      for (int p = 0; p < n_pkt; p++)
         gen_packet((p == n_pkt - 1 && $urandom_range(0, 3) == 0) ?
                    $urandom_range(1, TS_PACKET_BYTES - 1) : TS_PACKET_BYTES);
      if (byte_q.size() > start) begin
         byte_q[start].datagram_start = 1'b1;
         byte_q[start].slice_start    = new_slice;
      end
   endfunction

   // stray bytes with random markers, slice start alone included
   function automatic void gen_noise();
      repeat ($urandom_range(1, 16))
         push_byte(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
   endfunction

   // the phase is cut to exactly budget bytes, the last datagram may end early
   function automatic void build_phase(int budget);
      while (byte_q.size() < budget) begin
         if ($urandom_range(0, 7) == 0)
            gen_noise();
         else
            gen_datagram($urandom_range(0, 2) == 0);
      end
      while (byte_q.size() > budget)
         void'(byte_q.pop_back());
   endfunction

   // -------------------------------------------------------------------------
   // drivers
   // -------------------------------------------------------------------------
   // valid is left high, the caller lowers it when a gap or the end comes
   task automatic send_byte(tslpe_req_type r);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(r);
   endtask

   // bursts of random length with random gaps, some without any gap
   task automatic play_bytes();
      int burst_left;
      int gap;
      burst_left = 0;
      foreach (byte_q[i]) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) :
                                                       $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_byte(byte_q[i]);
         burst_left--;
      end
      req_valid <= 1'b0;
      byte_q.delete();
   endtask

   // sender paused until every sample is in, then room for bytes in flight
   task automatic drain();
      while (sb.samples_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes
   task automatic write_csr(tslpe_csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(int phase);
      logic [12:0] pid;
      logic [6:0]  rtp;
      logic [7:0]  pes;
      logic        swap;
      case (phase)
         1: begin
            pid = 13'($urandom); rtp = 7'd0;   pes = 8'd0;   swap = 1'b0;
         end
         2: begin
            // extreme field values are taken as written
            pid = 13'h1FFF;      rtp = 7'd127; pes = 8'd255; swap = 1'b1;
         end
         3: begin
            pid = 13'h0000;      rtp = 7'd64;  pes = 8'd184; swap = 1'b0;
         end
         5: begin
            pid = 13'($urandom); rtp = 7'd1;   pes = 8'd183; swap = 1'b1;
         end
         default: begin
            pid  = 13'($urandom);
            rtp  = 7'($urandom_range(0, 16));
            pes  = 8'($urandom_range(0, 40));
            swap = 1'($urandom);
         end
      endcase
      write_csr(CSR_TARGET_PID, pid);
      write_csr(CSR_RTP_HEADER_BYTES, CSR_DATA_W'(rtp));
      write_csr(CSR_PES_HEADER_SKIP, CSR_DATA_W'(pes));
      write_csr(CSR_SWAP_ENABLE, CSR_DATA_W'(swap));
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bytes before any datagram start parse from packet position 0,
      // sync byte not 0x47, pid 0x1100 payload only
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h11, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h10, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'hA5, 1'b0, 1'b0);
      // slice start alone acts as datagram start, the held odd byte is lost
      push_byte(8'h5A, 1'b0, 1'b1);
      for (int i = 0; i < 11; i++)
         push_byte((i % 2 == 0) ? 8'hFF : 8'h00, 1'b0, 1'b0);
      // header with pusi and adaptation field, then datagram start mid packet
      push_byte(8'h47, 1'b0, 1'b0);
      push_byte(8'h51, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h30, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b1);

      // phase 0 runs on reset values, later ones reprogram every register
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase != 0) begin
            drain();
            configure(phase);
         end
         build_phase(PHASE_BYTES);
         if (phase == 1 || phase == 5)
            hold_off_pending = 1'b1;
         play_bytes();
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.samples_due.size() == 0)
         $display("ts_lpcm_payload_extractor_top: match");
      else
         $display("ts_lpcm_payload_extractor_top: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tslpe_pkg.sv
hw/rtl/tslpe_csr.sv
hw/rtl/tslpe_parser.sv
hw/rtl/ts_lpcm_payload_extractor_top.sv
test/tb.sv
